// ----- rtl/core/los_pkg.sv -----
// ----------------------------------------------------------------------------
// los_pkg
// Field widths and fixed constants of the latency order statistics unit.
// ----------------------------------------------------------------------------
package los_pkg;

  localparam int unsigned LatW    = 32;
  localparam int unsigned CountW  = 9;
  localparam int unsigned MeanW   = 40;
  localparam int unsigned MedianW = 33;
  localparam int unsigned FracW   = 8;
  localparam int unsigned PctDiv  = 20;
  localparam int unsigned OutW    = CountW + 4 * LatW + MeanW + 1 + 1;
  localparam int unsigned OutBytesW = ((OutW + 7) / 8) * 8;

  localparam logic OpAdd    = 1'b0;
  localparam logic OpReport = 1'b1;

endpackage

// ----- rtl/core/latency_order_statistics_unit.sv -----
// ----------------------------------------------------------------------------
// latency_order_statistics_unit
// Latency sample store kept in ascending order with an on-demand report.
// ----------------------------------------------------------------------------
// Usage: the slave stream takes one beat per command. tuser = 0 adds the
// 32-bit latency in tdata to the sorted store; tuser = 1 requests a report.
// An add yields no output beat; a report yields one master beat with count,
// min, max, mean (8 fraction bits), twice the median, p95 and overflow flag.
// An add walks down the store one entry at a time, reading each entry
// through the memory read port and shifting it up through the write port
// while it exceeds the new sample, then writes the sample into the gap.
// A report first counts through the entries to derive the p95 index, then
// sweeps the store through the memory read port, and then runs the
// bit-serial divider for the mean.
// tready is low while a command runs and while a report beat waits.
// Reset empties the store and clears the overflow flag; no clearing pass.
// When the receiver stalls, the report beat holds until taken.
// ----------------------------------------------------------------------------
module latency_order_statistics_unit #(
  parameter int unsigned MAX_SAMPLES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [los_pkg::LatW-1:0]        s_axis_tdata,  // latency
  input  logic                            s_axis_tuser,  // op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // sample_count, min_latency, max_latency, mean_q8, median_x2,
  // p95_latency, overflowed, zero fill
  output logic [los_pkg::OutBytesW-1:0]   m_axis_tdata
);

  localparam int unsigned AW  = $clog2(MAX_SAMPLES);
  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW  = los_pkg::LatW + CW;
  localparam int unsigned NW  = SW + los_pkg::FracW;
  localparam int unsigned DCW = $clog2(NW + 1);
  localparam int unsigned LW  = los_pkg::LatW;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StInsRd  = 3'd1;
  localparam logic [2:0] StInsCmp = 3'd2;
  localparam logic [2:0] StRepCnt = 3'd3;
  localparam logic [2:0] StRepRd  = 3'd4;
  localparam logic [2:0] StRepAcc = 3'd5;
  localparam logic [2:0] StRepDiv = 3'd6;

  logic [LW-1:0] mem [MAX_SAMPLES];
  logic [LW-1:0] rd_data_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [LW-1:0] wr_data;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [LW-1:0] val_q, val_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [4:0]    r20_q, r20_d;
  logic [CW-1:0] q20_q, q20_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [NW-1:0] num_q, num_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic [LW-1:0] min_q, min_d, max_q, max_d, p95_q, p95_d, meda_q, meda_d;
  logic [LW-1:0] medb_q, medb_d;
  logic          ovalid_q, ovalid_d;
  logic [los_pkg::MeanW-1:0]   mean_q, mean_d;
  logic [los_pkg::MedianW-1:0] median_x2;
  logic [CW:0]   trial;
  logic [CW-1:0] half, pidx, last;
  logic [CW+8:0] count_ext;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign half  = count_q >> 1;
  assign last  = count_q - CW'(1);
  assign pidx  = last - q20_q;
  assign trial = {rem_q, num_q[NW-1]};

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    pos_d    = pos_q;
    val_d    = val_q;
    idx_d    = idx_q;
    r20_d    = r20_q;
    q20_d    = q20_q;
    sum_d    = sum_q;
    num_d    = num_q;
    rem_d    = rem_q;
    dcnt_d   = dcnt_q;
    min_d    = min_q;
    max_d    = max_q;
    p95_d    = p95_q;
    meda_d   = meda_q;
    medb_d   = medb_q;
    mean_d   = mean_q;
    ovalid_d = ovalid_q;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    rd_addr  = '0;
    wr_addr  = pos_q[AW-1:0];
    wr_data  = val_q;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          if (s_axis_tuser == los_pkg::OpAdd) begin
            if (count_q < CW'(MAX_SAMPLES)) begin
              pos_d   = count_q;
              val_d   = s_axis_tdata;
              state_d = StInsRd;
            end else begin
              ovf_d = 1'b1;
            end
          end else if (count_q == '0) begin
            min_d    = '0;
            max_d    = '0;
            p95_d    = '0;
            meda_d   = '0;
            medb_d   = '0;
            mean_d   = '0;
            ovalid_d = 1'b1;
          end else begin
            idx_d   = '0;
            r20_d   = '0;
            q20_d   = '0;
            sum_d   = '0;
            state_d = StRepCnt;
          end
        end
      end
      StInsRd: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
          state_d = StIdle;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(pos_q - CW'(1));
          state_d = StInsCmp;
        end
      end
      StInsCmp: begin
        wr_en = 1'b1;
        if (rd_data_q > val_q) begin
          wr_data = rd_data_q;
          pos_d   = pos_q - CW'(1);
          state_d = StInsRd;
        end else begin
          count_d = count_q + CW'(1);
          state_d = StIdle;
        end
      end
      StRepCnt: begin
        if (r20_q == 5'(los_pkg::PctDiv - 1)) begin
          r20_d = '0;
          q20_d = q20_q + CW'(1);
        end else begin
          r20_d = r20_q + 5'd1;
        end
        idx_d = idx_q + CW'(1);
        if (idx_q == last) begin
          idx_d   = '0;
          state_d = StRepRd;
        end
      end
      StRepRd: begin
        rd_en   = 1'b1;
        rd_addr = idx_q[AW-1:0];
        state_d = StRepAcc;
      end
      StRepAcc: begin
        sum_d = sum_q + SW'(rd_data_q);
        if (idx_q == '0)   min_d = rd_data_q;
        if (idx_q == last) max_d = rd_data_q;
        if (idx_q == pidx) p95_d = rd_data_q;
        if (idx_q == half - CW'(1)) meda_d = rd_data_q;
        if (idx_q == half) medb_d = rd_data_q;
        idx_d   = idx_q + CW'(1);
        state_d = StRepRd;
        if (idx_q == last) begin
          num_d   = {sum_d, los_pkg::FracW'(0)};
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = StRepDiv;
        end
      end
      StRepDiv: begin
        if (trial >= {1'b0, count_q}) begin
          rem_d = CW'(trial - {1'b0, count_q});
          num_d = {num_q[NW-2:0], 1'b1};
        end else begin
          rem_d = trial[CW-1:0];
          num_d = {num_q[NW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(NW - 1)) begin
          mean_d   = num_d[los_pkg::MeanW-1:0];
          ovalid_d = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    val_q  <= val_d;
    idx_q  <= idx_d;
    r20_q  <= r20_d;
    q20_q  <= q20_d;
    sum_q  <= sum_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    dcnt_q <= dcnt_d;
    min_q  <= min_d;
    max_q  <= max_d;
    p95_q  <= p95_d;
    meda_q <= meda_d;
    medb_q <= medb_d;
    mean_q <= mean_d;
  end

  assign median_x2 = count_q[0] ? ({1'b0, medb_q} + {1'b0, medb_q})
                                : ({1'b0, meda_q} + {1'b0, medb_q});
  assign count_ext = {9'd0, count_q};

  assign s_axis_tready = (state_q == StIdle) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = los_pkg::OutBytesW'({ovf_q, p95_q, median_x2, mean_q,
                                               max_q, min_q, count_ext[8:0]});

endmodule
